@@ sv/pdr_pkg.sv @@
package pdr_pkg;

  localparam int unsigned PC_W = 4;
  localparam int unsigned ATAN_IDX_W = 5;

  localparam logic [23:0] PERIOD_RESET = 24'd167772;

  // Start value of the rotation: the reciprocal of the gain of an endless CORDIC, Q0.30.
  localparam logic [29:0] CORDIC_GAIN = 30'd652032874;

  // One radian in binary-angle units, round(2^32 / (2*pi)).
  localparam logic [29:0] TURN_PER_RAD = 30'd683565276;

  localparam logic [31:0] ATAN_TURNS [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  // Program step addresses.
  localparam logic [PC_W-1:0] PC_IDLE   = 4'd0;
  localparam logic [PC_W-1:0] PC_ROT    = 4'd1;
  localparam logic [PC_W-1:0] PC_MUL_VC = 4'd2;
  localparam logic [PC_W-1:0] PC_MUL_XT = 4'd3;
  localparam logic [PC_W-1:0] PC_ADD_X  = 4'd4;
  localparam logic [PC_W-1:0] PC_MUL_VS = 4'd5;
  localparam logic [PC_W-1:0] PC_MUL_YT = 4'd6;
  localparam logic [PC_W-1:0] PC_ADD_Y  = 4'd7;
  localparam logic [PC_W-1:0] PC_MUL_WT = 4'd8;
  localparam logic [PC_W-1:0] PC_MUL_LK = 4'd9;
  localparam logic [PC_W-1:0] PC_MUL_HK = 4'd10;
  localparam logic [PC_W-1:0] PC_HDG    = 4'd11;
  localparam logic [PC_W-1:0] PC_OUT    = 4'd12;

  typedef enum logic [3:0] {
    OP_LOAD,
    OP_ROT,
    OP_MUL_VC,
    OP_MUL_VS,
    OP_MUL_ST,
    OP_ADD_X,
    OP_ADD_Y,
    OP_MUL_WT,
    OP_MUL_LK,
    OP_MUL_HK,
    OP_HDG,
    OP_OUT
  } pdr_op_e;

  typedef enum logic [1:0] {
    SEQ_NEXT,
    SEQ_WAIT_IN,
    SEQ_LOOP,
    SEQ_WAIT_OUT
  } pdr_seq_e;

  typedef struct packed {
    pdr_op_e             op;
    pdr_seq_e            seq;
    logic [PC_W-1:0]     target;
  } pdr_uword_t;

  typedef struct packed {
    logic in_fire;
    logic out_free;
  } pdr_cond_t;

  typedef struct packed {
    pdr_op_e               op;
    logic [ATAN_IDX_W-1:0] iter;
  } pdr_ctrl_t;

  typedef struct packed {
    logic signed [31:0] linear_velocity;
    logic signed [31:0] angular_rate;
  } pdr_in_t;

  typedef struct packed {
    logic signed [47:0] pos_x;
    logic signed [47:0] pos_y;
    logic [31:0]        heading;
  } pdr_out_t;

endpackage

@@ sv/pdr_useq.sv @@
module pdr_useq #(
  parameter int unsigned TRIG_ITERATIONS = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pdr_pkg::pdr_cond_t cond_i,
  output pdr_pkg::pdr_ctrl_t ctrl_o
);

  localparam int unsigned ITER_W = $clog2(TRIG_ITERATIONS);

  logic [pdr_pkg::PC_W-1:0] pc_q, pc_d;
  logic [ITER_W-1:0]        cnt_q, cnt_d;
  pdr_pkg::pdr_uword_t      uw;
  logic                     last;

  function automatic pdr_pkg::pdr_uword_t urom(input logic [pdr_pkg::PC_W-1:0] pc);
    pdr_pkg::pdr_uword_t w;
    w = '{op: pdr_pkg::OP_LOAD, seq: pdr_pkg::SEQ_WAIT_IN, target: pdr_pkg::PC_ROT};
    unique case (pc)
      pdr_pkg::PC_IDLE: begin
        w = '{op: pdr_pkg::OP_LOAD, seq: pdr_pkg::SEQ_WAIT_IN, target: pdr_pkg::PC_ROT};
      end
      pdr_pkg::PC_ROT: begin
        w = '{op: pdr_pkg::OP_ROT, seq: pdr_pkg::SEQ_LOOP, target: pdr_pkg::PC_MUL_VC};
      end
      pdr_pkg::PC_MUL_VC: begin
        w = '{op: pdr_pkg::OP_MUL_VC, seq: pdr_pkg::SEQ_NEXT, target: pdr_pkg::PC_IDLE};
      end
      pdr_pkg::PC_MUL_XT: begin
        w = '{op: pdr_pkg::OP_MUL_ST, seq: pdr_pkg::SEQ_NEXT, target: pdr_pkg::PC_IDLE};
      end
      pdr_pkg::PC_ADD_X: begin
        w = '{op: pdr_pkg::OP_ADD_X, seq: pdr_pkg::SEQ_NEXT, target: pdr_pkg::PC_IDLE};
      end
      pdr_pkg::PC_MUL_VS: begin
        w = '{op: pdr_pkg::OP_MUL_VS, seq: pdr_pkg::SEQ_NEXT, target: pdr_pkg::PC_IDLE};
      end
      pdr_pkg::PC_MUL_YT: begin
        w = '{op: pdr_pkg::OP_MUL_ST, seq: pdr_pkg::SEQ_NEXT, target: pdr_pkg::PC_IDLE};
      end
      pdr_pkg::PC_ADD_Y: begin
        w = '{op: pdr_pkg::OP_ADD_Y, seq: pdr_pkg::SEQ_NEXT, target: pdr_pkg::PC_IDLE};
      end
      pdr_pkg::PC_MUL_WT: begin
        w = '{op: pdr_pkg::OP_MUL_WT, seq: pdr_pkg::SEQ_NEXT, target: pdr_pkg::PC_IDLE};
      end
      pdr_pkg::PC_MUL_LK: begin
        w = '{op: pdr_pkg::OP_MUL_LK, seq: pdr_pkg::SEQ_NEXT, target: pdr_pkg::PC_IDLE};
      end
      pdr_pkg::PC_MUL_HK: begin
        w = '{op: pdr_pkg::OP_MUL_HK, seq: pdr_pkg::SEQ_NEXT, target: pdr_pkg::PC_IDLE};
      end
      pdr_pkg::PC_HDG: begin
        w = '{op: pdr_pkg::OP_HDG, seq: pdr_pkg::SEQ_NEXT, target: pdr_pkg::PC_IDLE};
      end
      pdr_pkg::PC_OUT: begin
        w = '{op: pdr_pkg::OP_OUT, seq: pdr_pkg::SEQ_WAIT_OUT, target: pdr_pkg::PC_IDLE};
      end
      default: begin
        w = '{op: pdr_pkg::OP_LOAD, seq: pdr_pkg::SEQ_WAIT_IN, target: pdr_pkg::PC_ROT};
      end
    endcase
    return w;
  endfunction

  assign uw   = urom(pc_q);
  assign last = (cnt_q == ITER_W'(TRIG_ITERATIONS - 1));

  always_comb begin
    unique case (uw.seq)
      pdr_pkg::SEQ_NEXT:     pc_d = pdr_pkg::PC_W'(pc_q + 1'b1);
      pdr_pkg::SEQ_WAIT_IN:  pc_d = cond_i.in_fire ? uw.target : pc_q;
      pdr_pkg::SEQ_LOOP:     pc_d = last ? uw.target : pc_q;
      pdr_pkg::SEQ_WAIT_OUT: pc_d = cond_i.out_free ? uw.target : pc_q;
      default:               pc_d = pdr_pkg::PC_IDLE;
    endcase
  end

  // The loop counter counts rotation rounds and rests at zero elsewhere.
  assign cnt_d = (uw.op == pdr_pkg::OP_ROT && !last) ? ITER_W'(cnt_q + 1'b1) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q  <= pdr_pkg::PC_IDLE;
      cnt_q <= '0;
    end else begin
      pc_q  <= pc_d;
      cnt_q <= cnt_d;
    end
  end

  assign ctrl_o.op   = uw.op;
  assign ctrl_o.iter = pdr_pkg::ATAN_IDX_W'(cnt_q);

  a_pc_in_program: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pc_q <= pdr_pkg::PC_OUT)
    else $error("step counter left the program");

  a_rot_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (uw.op == pdr_pkg::OP_ROT && !last)
      |=> (uw.op == pdr_pkg::OP_ROT && cnt_q == ITER_W'($past(cnt_q) + 1'b1)))
    else $error("rotation loop skipped or repeated a round");

  a_cnt_rests: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (uw.op != pdr_pkg::OP_ROT) |-> (cnt_q == '0))
    else $error("loop counter not at zero outside the rotation loop");

endmodule

@@ sv/pose_dead_reckoning_integrator.sv @@
// Channel  Direction  Handshake              Beat
// in       input      in_valid_i/in_stall_o  pdr_in_t: linear velocity, angular rate
// out      output     out_valid_o/out_stall_i pdr_out_t: x, y, heading
// cfg      input      cfg_valid_i/cfg_ready_o sample period, Q0.24
//
// An item runs through one load step, one step per CORDIC round in the shared shift-add
// unit, ten multiply and add steps around the one 34x34 multiplier, and one step that
// hands the result to the output register; the input is stalled until that step is done.
// A waiting result does not block the next input beat; only the final step waits on out_stall_i.
// Reset clears the pose to zero and loads the default sample period.
module pose_dead_reckoning_integrator #(
  parameter int unsigned TRIG_ITERATIONS = 24
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  pdr_pkg::pdr_in_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output pdr_pkg::pdr_out_t out_data_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [23:0]      cfg_data_i
);

  pdr_pkg::pdr_ctrl_t ctrl;
  pdr_pkg::pdr_cond_t cond;

  logic in_fire, out_free, out_load, mul_en;

  logic [23:0]        period_q;
  logic signed [47:0] x_q, x_d;
  logic signed [47:0] y_q, y_d;
  logic [31:0]        hdg_q, hdg_d;

  logic signed [31:0] v_q, w_q;
  logic signed [33:0] cx_q, cy_q, cz_q;
  logic               flip_q;
  logic signed [67:0] prod_q, prod_d;
  logic signed [33:0] aux_q, aux_d;

  logic signed [33:0] op_a, op_b, c_val, s_val, dx, dy, atan;
  logic [31:0]        fold_add, za;
  logic               fold_flip;
  logic [39:0]        hsum;

  pdr_pkg::pdr_out_t  out_q;
  logic               out_valid_q;

  pdr_useq #(
    .TRIG_ITERATIONS(TRIG_ITERATIONS)
  ) u_useq (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cond_i(cond),
    .ctrl_o(ctrl)
  );

  assign in_stall_o    = (ctrl.op != pdr_pkg::OP_LOAD);
  assign in_fire       = in_valid_i && !in_stall_o;
  assign out_free      = !out_valid_q || !out_stall_i;
  assign out_load      = (ctrl.op == pdr_pkg::OP_OUT) && out_free;
  assign cond.in_fire  = in_fire;
  assign cond.out_free = out_free;
  assign cfg_ready_o   = 1'b1;

  function automatic logic signed [47:0] sat_add(input logic signed [47:0] pos,
                                                  input logic signed [39:0] inc);
    logic signed [49:0] sum;
    sum = 50'(pos) + 50'(inc);
    if (sum[49:47] == 3'b000 || sum[49:47] == 3'b111) begin
      return sum[47:0];
    end else if (sum[49]) begin
      return {1'b1, {47{1'b0}}};
    end else begin
      return {1'b0, {47{1'b1}}};
    end
  endfunction

  // Fold the heading into the right half plane; the half turn is undone by negating.
  assign fold_add  = hdg_q + 32'h4000_0000;
  assign fold_flip = fold_add[31];
  assign za        = fold_flip ? (hdg_q ^ 32'h8000_0000) : hdg_q;

  assign c_val = flip_q ? -cx_q : cx_q;
  assign s_val = flip_q ? -cy_q : cy_q;
  assign dx    = cy_q >>> ctrl.iter;
  assign dy    = cx_q >>> ctrl.iter;
  assign atan  = 34'(pdr_pkg::ATAN_TURNS[ctrl.iter]);

  always_comb begin
    op_a   = '0;
    op_b   = '0;
    mul_en = 1'b0;
    aux_d  = aux_q;
    case (ctrl.op)
      pdr_pkg::OP_MUL_VC: begin
        op_a   = 34'(v_q);
        op_b   = c_val;
        mul_en = 1'b1;
      end
      pdr_pkg::OP_MUL_VS: begin
        op_a   = 34'(v_q);
        op_b   = s_val;
        mul_en = 1'b1;
      end
      pdr_pkg::OP_MUL_ST: begin
        // Speed is the velocity-trig product floored by 2^30.
        op_a   = prod_q[63:30];
        op_b   = {10'b0, period_q};
        mul_en = 1'b1;
      end
      pdr_pkg::OP_MUL_WT: begin
        op_a   = 34'(w_q);
        op_b   = {10'b0, period_q};
        mul_en = 1'b1;
      end
      pdr_pkg::OP_MUL_LK: begin
        // Low word of w*T times the constant; keep the signed high part for the next step.
        op_a   = {2'b0, prod_q[31:0]};
        op_b   = {4'b0, pdr_pkg::TURN_PER_RAD};
        aux_d  = 34'($signed(prod_q[55:32]));
        mul_en = 1'b1;
      end
      pdr_pkg::OP_MUL_HK: begin
        op_a   = aux_q;
        op_b   = {4'b0, pdr_pkg::TURN_PER_RAD};
        aux_d  = {4'b0, prod_q[61:32]};
        mul_en = 1'b1;
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  assign prod_d = op_a * op_b;

  // Heading step is bits 71:40 of the full product, rebuilt from the two partial products.
  assign hsum = prod_q[39:0] + 40'(aux_q);

  always_comb begin
    x_d   = x_q;
    y_d   = y_q;
    hdg_d = hdg_q;
    case (ctrl.op)
      pdr_pkg::OP_ADD_X: x_d   = sat_add(x_q, prod_q[63:24]);
      pdr_pkg::OP_ADD_Y: y_d   = sat_add(y_q, prod_q[63:24]);
      pdr_pkg::OP_HDG:   hdg_d = hdg_q + hsum[39:8];
      default: begin
        x_d = x_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q    <= pdr_pkg::PERIOD_RESET;
      x_q         <= '0;
      y_q         <= '0;
      hdg_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        period_q <= cfg_data_i;
      end
      x_q   <= x_d;
      y_q   <= y_d;
      hdg_q <= hdg_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      v_q    <= in_data_i.linear_velocity;
      w_q    <= in_data_i.angular_rate;
      cx_q   <= 34'(pdr_pkg::CORDIC_GAIN);
      cy_q   <= '0;
      cz_q   <= 34'($signed(za));
      flip_q <= fold_flip;
    end else if (ctrl.op == pdr_pkg::OP_ROT) begin
      if (!cz_q[33]) begin
        cx_q <= cx_q - dx;
        cy_q <= cy_q + dy;
        cz_q <= cz_q - atan;
      end else begin
        cx_q <= cx_q + dx;
        cy_q <= cy_q - dy;
        cz_q <= cz_q + atan;
      end
    end
    if (mul_en) begin
      prod_q <= prod_d;
    end
    aux_q <= aux_d;
    if (out_load) begin
      out_q.pos_x   <= x_q;
      out_q.pos_y   <= y_q;
      out_q.heading <= hdg_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> in_stall_o)
    else $error("input beat taken while an update is still running");

  a_fold_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (cz_q[33:30] == 4'b0000 || cz_q[33:30] == 4'b1111))
    else $error("folded angle outside the right half plane");

  a_result_matches_pose: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (out_q.pos_x == x_q && out_q.pos_y == y_q && out_q.heading == hdg_q))
    else $error("result register does not match the stored pose");

endmodule

@@ test/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TRIG_ROUNDS = 24;
  localparam int unsigned STEP_LATENCY = TRIG_ROUNDS + 12;
  localparam int unsigned SETTLE_LIMIT = 20000;
  localparam int unsigned RANDOM_ITEMS = 590;
  localparam int unsigned HOLD_OFF_CYCLES = 400;

  localparam logic [23:0] PERIOD_AT_RESET = 24'd167772;
  localparam logic [23:0] PERIOD_MAX = 24'hFFFFFF;

  localparam longint ROT_GAIN = 64'sd652032874;
  localparam longint POS_HI = 64'sd140737488355327;
  localparam longint POS_LO = -64'sd140737488355328;
  localparam logic signed [127:0] RAD_TO_TURN = 128'sd683565276;

  localparam longint ARCTAN_STEP [TRIG_ROUNDS] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
    64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
    64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D,
    64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
    64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
  };

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_stall_o;
  pdr_pkg::pdr_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  pdr_pkg::pdr_out_t out_data_o;
  logic     cfg_valid_i = 1'b0;
  logic     cfg_ready_o;
  logic [23:0] cfg_data_i = '0;

  // Predicted pose and the period the block is running with.
  logic signed [47:0] x_pos;
  logic signed [47:0] y_pos;
  logic [31:0]        hdg;
  logic [23:0]        period_now;

  pdr_pkg::pdr_out_t expected_poses [$];
  pdr_pkg::pdr_out_t oldest_pose;
  int unsigned mismatches = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_left = 0;

  pose_dead_reckoning_integrator #(
    .TRIG_ITERATIONS(TRIG_ROUNDS)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Shift-add rotation of the unit vector to the stored heading.
  function automatic void heading_trig(input logic [31:0] ang, output longint cos_v,
                                       output longint sin_v);
    logic [31:0] folded;
    logic        half;
    longint      xr;
    longint      yr;
    longint      zr;
    longint      dx;
    longint      dy;
    folded = ang + 32'h4000_0000;
    half = folded[31];
    folded = half ? ang - 32'h8000_0000 : ang;
    zr = {{32{folded[31]}}, folded};
    xr = ROT_GAIN;
    yr = 0;
    for (int i = 0; i < TRIG_ROUNDS; i++) begin
      dx = yr >>> i;
      dy = xr >>> i;
      if (zr >= 0) begin
        xr -= dx;
        yr += dy;
        zr -= ARCTAN_STEP[i];
      end else begin
        xr += dx;
        yr -= dy;
        zr += ARCTAN_STEP[i];
      end
    end
    cos_v = half ? -xr : xr;
    sin_v = half ? -yr : yr;
  endfunction

  function automatic logic signed [47:0] project(input logic signed [47:0] pos,
                                                 input longint vel, input longint trig);
    longint per;
    longint speed;
    longint sum;
    per = longint'(period_now);
    sum = longint'(pos);
    speed = (vel * trig) >>> 30;
    sum += (speed * per) >>> 24;
    if (sum > POS_HI) sum = POS_HI;
    if (sum < POS_LO) sum = POS_LO;
    return sum[47:0];
  endfunction

  // Rate times period is Q16.40 radians; scaling to turns keeps bits 71:40.
  function automatic logic [31:0] turn_step(input longint rate);
    longint per;
    logic signed [127:0] wide;
    per = longint'(period_now);
    wide = 128'(rate) * 128'(per);
    wide = wide * RAD_TO_TURN;
    return wide[71:40];
  endfunction

  function automatic pdr_pkg::pdr_out_t step_pose(input pdr_pkg::pdr_in_t motion);
    longint   c;
    longint   s;
    longint   vel;
    longint   rate;
    pdr_pkg::pdr_out_t pose;
    vel = longint'(motion.linear_velocity);
    rate = longint'(motion.angular_rate);
    heading_trig(hdg, c, s);
    x_pos = project(x_pos, vel, c);
    y_pos = project(y_pos, vel, s);
    hdg = hdg + turn_step(rate);
    pose.pos_x = x_pos;
    pose.pos_y = y_pos;
    pose.heading = hdg;
    return pose;
  endfunction

  function automatic logic [31:0] extreme_word();
    case ($urandom_range(0, 4))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'h0000_0001;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  function automatic pdr_pkg::pdr_in_t random_motion();
    pdr_pkg::pdr_in_t motion;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        motion.linear_velocity = $urandom;
        motion.angular_rate = $urandom;
      end
      3: begin
        motion.linear_velocity = extreme_word();
        motion.angular_rate = extreme_word();
      end
      4: begin
        motion.linear_velocity = extreme_word();
        motion.angular_rate = $urandom;
      end
      default: begin
        // Plausible speeds: a few meters per second, a few radians per second.
        motion.linear_velocity = int'($urandom_range(0, 1 << 20)) - (1 << 19);
        motion.angular_rate = int'($urandom_range(0, 1 << 19)) - (1 << 18);
      end
    endcase
    return motion;
  endfunction

  task automatic log_mismatch(input string what, input logic [63:0] want,
                              input logic [63:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch %s: expected %h, got %h", what, want, got);
    end
  endtask

  // Offers one beat, holding it until the block takes it, and records the
  // pose that beat should produce.
  task automatic send_motion(input logic signed [31:0] vel, input logic signed [31:0] rate);
    pdr_pkg::pdr_in_t motion;
    motion.linear_velocity = vel;
    motion.angular_rate = rate;
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= motion;
    do @(posedge clk_i); while (in_stall_o);
    expected_poses.push_back(step_pose(motion));
  endtask

  task automatic send_random(input int unsigned count);
    pdr_pkg::pdr_in_t motion;
    repeat (count) begin
      motion = random_motion();
      send_motion(motion.linear_velocity, motion.angular_rate);
    end
  endtask

  // Lets the block run dry before anything that needs it idle.
  task automatic settle();
    int unsigned waited;
    waited = 0;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_poses.size() != 0 && waited < SETTLE_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    if (expected_poses.size() != 0) begin
      log_mismatch("missing results", 64'(expected_poses.size()), 64'd0);
      expected_poses.delete();
    end
    repeat (STEP_LATENCY) @(posedge clk_i);
  endtask

  task automatic write_period(input logic [23:0] period);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= period;
    do @(posedge clk_i); while (!cfg_ready_o);
    period_now = period;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_default_period();
    send_motion(32'sd0, 32'sd0);
    send_motion(32'sh7FFF_FFFF, 32'sd0);
    send_motion(32'sh8000_0000, 32'sd0);
    send_motion(32'sd1, 32'sd1);
    send_motion(-32'sd1, -32'sd1);
    send_motion(32'sh0001_0000, 32'sh0001_921F);
    send_motion(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_motion(32'sh8000_0000, 32'sh8000_0000);
    settle();
  endtask

  task automatic test_period_extremes();
    write_period(PERIOD_MAX);
    // Large turn rates over a long step wrap the heading many times.
    send_motion(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_motion(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_motion(32'sh8000_0000, 32'sh8000_0000);
    send_motion(32'sh8000_0000, 32'sh4000_0000);
    send_motion(32'sh5555_5555, 32'shAAAA_AAAA);
    send_motion(32'shAAAA_AAAA, 32'sh5555_5555);
    settle();
    // With no time step the pose must not move at all.
    write_period(24'd0);
    send_motion(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_motion(32'sh8000_0000, 32'sh8000_0000);
    send_motion(32'sh1234_5678, -32'sh0765_4321);
    settle();
    write_period(24'd1);
    send_motion(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_motion(32'sh8000_0000, 32'sh8000_0000);
    send_motion(-32'sd1, 32'sd1);
    settle();
  endtask

  task automatic test_random_traffic(input logic [23:0] period, input int unsigned send_pct,
                                     input int unsigned recv_pct);
    write_period(period);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    send_random(RANDOM_ITEMS);
    settle();
  endtask

  // The output side stops taking results while beats keep coming, so the
  // block has to stall its input until the hold-off ends.
  task automatic test_output_hold_off();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_left = HOLD_OFF_CYCLES;
    send_random(12);
    settle();
  endtask

  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_poses.size() == 0) begin
        log_mismatch("unexpected heading", 64'd0, 64'(out_data_o.heading));
      end else begin
        oldest_pose = expected_poses.pop_front();
        if (out_data_o.pos_x !== oldest_pose.pos_x) begin
          log_mismatch("pos_x", 64'(oldest_pose.pos_x), 64'(out_data_o.pos_x));
        end
        if (out_data_o.pos_y !== oldest_pose.pos_y) begin
          log_mismatch("pos_y", 64'(oldest_pose.pos_y), 64'(out_data_o.pos_y));
        end
        if (out_data_o.heading !== oldest_pose.heading) begin
          log_mismatch("heading", 64'(oldest_pose.heading), 64'(out_data_o.heading));
        end
      end
    end
  end

  initial begin
    x_pos = '0;
    y_pos = '0;
    hdg = '0;
    period_now = PERIOD_AT_RESET;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_default_period();
    test_period_extremes();
    test_random_traffic(24'($urandom_range(2, PERIOD_MAX - 1)), 17, 58);
    test_random_traffic(24'($urandom_range(1, 4096)), 58, 17);
    test_output_hold_off();
    test_random_traffic(PERIOD_MAX, 0, 0);

    if (mismatches == 0) begin
      $display("pose_dead_reckoning_integrator verification clean");
    end else begin
      $display("pose_dead_reckoning_integrator verification failed");
    end
    $finish;
  end

  initial begin
    #(8_000_000);
    $display("pose_dead_reckoning_integrator verification failed");
    $finish;
  end

endmodule

@@ pose_dead_reckoning_integrator.f @@
sv/pdr_pkg.sv
sv/pdr_useq.sv
sv/pose_dead_reckoning_integrator.sv
test/testbench.sv
